// ===== src/rep_pkg.sv =====
// ----------------------------------------------------------------------------
// rep_pkg: shared constants for the ellipse polygon vertex generator
// Holds the CORDIC table, the gain start value, the per-count angle step
// table and the widths of the datapath.
// ----------------------------------------------------------------------------
package rep_pkg;

  // Largest vertex count a request may ask for.
  localparam int MaxVertexCount = 63;

  // CORDIC settings.
  localparam int CordicSteps = 24;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  typedef logic [4:0] cstep_t;
  typedef logic signed [31:0] angle_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic angle_t atan_of(input cstep_t i);
    angle_t v;
    begin
      case (i)
        5'd0: v = 32'sd536870912;
        5'd1: v = 32'sd316933406;
        5'd2: v = 32'sd167458907;
        5'd3: v = 32'sd85004756;
        5'd4: v = 32'sd42667331;
        5'd5: v = 32'sd21354465;
        5'd6: v = 32'sd10679838;
        5'd7: v = 32'sd5340245;
        5'd8: v = 32'sd2670163;
        5'd9: v = 32'sd1335087;
        5'd10: v = 32'sd667544;
        5'd11: v = 32'sd333772;
        5'd12: v = 32'sd166886;
        5'd13: v = 32'sd83443;
        5'd14: v = 32'sd41722;
        5'd15: v = 32'sd20861;
        5'd16: v = 32'sd10430;
        5'd17: v = 32'sd5215;
        5'd18: v = 32'sd2608;
        5'd19: v = 32'sd1304;
        5'd20: v = 32'sd652;
        5'd21: v = 32'sd326;
        5'd22: v = 32'sd163;
        5'd23: v = 32'sd81;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

  // One full turn in units of 2^32 per turn.
  localparam longint unsigned OneTurn = 64'h1_0000_0000;

  // Angle step per vertex: one full turn divided by the count, as a
  // constant table. A count of one wraps to a zero step.
  typedef logic [31:0] step_tab_t [0:63];

  localparam step_tab_t StepTab = '{
    32'd0,               32'(OneTurn / 1),    32'(OneTurn / 2),    32'(OneTurn / 3),
    32'(OneTurn / 4),    32'(OneTurn / 5),    32'(OneTurn / 6),    32'(OneTurn / 7),
    32'(OneTurn / 8),    32'(OneTurn / 9),    32'(OneTurn / 10),   32'(OneTurn / 11),
    32'(OneTurn / 12),   32'(OneTurn / 13),   32'(OneTurn / 14),   32'(OneTurn / 15),
    32'(OneTurn / 16),   32'(OneTurn / 17),   32'(OneTurn / 18),   32'(OneTurn / 19),
    32'(OneTurn / 20),   32'(OneTurn / 21),   32'(OneTurn / 22),   32'(OneTurn / 23),
    32'(OneTurn / 24),   32'(OneTurn / 25),   32'(OneTurn / 26),   32'(OneTurn / 27),
    32'(OneTurn / 28),   32'(OneTurn / 29),   32'(OneTurn / 30),   32'(OneTurn / 31),
    32'(OneTurn / 32),   32'(OneTurn / 33),   32'(OneTurn / 34),   32'(OneTurn / 35),
    32'(OneTurn / 36),   32'(OneTurn / 37),   32'(OneTurn / 38),   32'(OneTurn / 39),
    32'(OneTurn / 40),   32'(OneTurn / 41),   32'(OneTurn / 42),   32'(OneTurn / 43),
    32'(OneTurn / 44),   32'(OneTurn / 45),   32'(OneTurn / 46),   32'(OneTurn / 47),
    32'(OneTurn / 48),   32'(OneTurn / 49),   32'(OneTurn / 50),   32'(OneTurn / 51),
    32'(OneTurn / 52),   32'(OneTurn / 53),   32'(OneTurn / 54),   32'(OneTurn / 55),
    32'(OneTurn / 56),   32'(OneTurn / 57),   32'(OneTurn / 58),   32'(OneTurn / 59),
    32'(OneTurn / 60),   32'(OneTurn / 61),   32'(OneTurn / 62),   32'(OneTurn / 63)
  };

endpackage

// ===== src/rep_cordic.sv =====
// ----------------------------------------------------------------------------
// rep_cordic: iterative sine and cosine unit
// One CORDIC micro-rotation per cycle, with the quadrant folded back in
// from the top two angle bits.
// ----------------------------------------------------------------------------
module rep_cordic (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [15:0] ang,
  output logic done,
  output logic signed [rep_pkg::CordicW-1:0] cos_o,
  output logic signed [rep_pkg::CordicW-1:0] sin_o
);

  logic signed [rep_pkg::CordicW-1:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [1:0] q_r;
  logic [4:0] it_r;
  logic busy_r, done_r;
  logic signed [rep_pkg::CordicW-1:0] dx, dy;

  // Shifted terms for the current micro-rotation.
  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;

  // Control: iteration counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r <= '0;
      end else if (busy_r) begin
        if (it_r == 5'(rep_pkg::CordicSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        it_r <= it_r + 5'd1;
      end
    end
  end

  // Datapath: rotate toward zero residual angle.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= rep_pkg::CordicGain;
      y_r <= '0;
      z_r <= signed'({2'b00, ang[13:0], 16'b0});
      q_r <= ang[15:14];
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - rep_pkg::atan_of(it_r);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + rep_pkg::atan_of(it_r);
      end
    end
  end

  // Quadrant correction.
  always_comb begin
    case (q_r)
      2'd0: begin cos_o = x_r; sin_o = y_r; end
      2'd1: begin cos_o = -y_r; sin_o = x_r; end
      2'd2: begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r; sin_o = -x_r; end
    endcase
  end

  assign done = done_r;

endmodule

// ===== src/rotated_ellipse_polygon_vertices.sv =====
// ----------------------------------------------------------------------------
// rotated_ellipse_polygon_vertices: closed polygon vertex generator
// Emits the N+1 vertices of a rotated ellipse polygon as a line strip.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle; it then produces N+1
// vertices (N = vertex_count, zero counted as one), the last repeating the
// first. The rotation sine and cosine are computed first; then each vertex
// passes through the shared CORDIC unit and the shared multiplier (six
// products, each in a multiply and an accumulate state) and is handed to
// the output register. The output register lets a new request start while
// the closing vertex still waits for transfer.
module rotated_ellipse_polygon_vertices (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic [15:0] in_radius,
  input  logic [5:0] in_vertex_count,
  input  logic [15:0] in_rotation,
  input  logic [31:0] in_color,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [19:0] out_vertex_x,
  output logic signed [19:0] out_vertex_y,
  output logic [31:0] out_vertex_color,
  output logic [5:0] out_vertex_index,
  output logic out_last
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ROT = 4'd1;
  localparam logic [3:0] ST_VSTART = 4'd2;
  localparam logic [3:0] ST_VWAIT = 4'd3;
  localparam logic [3:0] ST_MUL = 4'd4;
  localparam logic [3:0] ST_ACC = 4'd5;
  localparam logic [3:0] ST_EMIT = 4'd6;
  localparam logic [3:0] ST_CLOSE = 4'd7;

  localparam logic [2:0] OP_EX = 3'd0;
  localparam logic [2:0] OP_EY = 3'd1;
  localparam logic [2:0] OP_XA = 3'd2;
  localparam logic [2:0] OP_XB = 3'd3;
  localparam logic [2:0] OP_YA = 3'd4;
  localparam logic [2:0] OP_YB = 3'd5;

  localparam int CW = rep_pkg::CordicW;

  logic [3:0] state_r;
  logic [2:0] op_r;
  logic [5:0] idx_r, n_r;
  logic [31:0] ang_r, step_r;
  logic signed [15:0] cx_r, cy_r;
  logic [15:0] r_r;
  logic [31:0] col_r;
  logic signed [CW-1:0] cr_r, sr_r, ca_r, sa_r;
  logic signed [CW-1:0] ex_r, ey_r;
  logic signed [68:0] prod_r;
  logic signed [69:0] acc_r;
  logic signed [19:0] vx_r, vy_r, fx_r, fy_r;
  logic out_valid_r, out_last_r;
  logic signed [19:0] out_x_r, out_y_r;
  logic [31:0] out_col_r;
  logic [5:0] out_idx_r;

  logic accept, out_free, out_load, cor_start, cor_done;
  logic [15:0] cor_ang;
  logic signed [CW-1:0] cor_cos, cor_sin;
  logic signed [34:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic [5:0] n_in;
  logic signed [68:0] rnd15;
  logic signed [69:0] sum_x, sum_y;
  logic signed [19:0] fin_x, fin_y;

  // Round half up from Q45 to Q0, add the center and saturate.
  function automatic logic signed [19:0] finish(input logic signed [69:0] v,
                                                input logic signed [15:0] c);
    logic signed [69:0] t;
    logic signed [25:0] s;
    begin
      t = v + (70'sd1 <<< 44);
      s = 26'(signed'(t[69:45])) + 26'(c);
      if (s > 26'sd524287) return 20'sd524287;
      else if (s < -26'sd524288) return -20'sd524288;
      else return s[19:0];
    end
  endfunction

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = ((state_r == ST_EMIT) || (state_r == ST_CLOSE)) && out_free;
  assign n_in = (in_vertex_count == 6'd0) ? 6'd1 : in_vertex_count;

  // Shared sine and cosine unit.
  assign cor_start = accept || (state_r == ST_VSTART);
  assign cor_ang = accept ? in_rotation : ang_r[31:16];

  rep_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .ang   (cor_ang),
    .done  (cor_done),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op_r)
      OP_EX: begin mul_a = 35'(signed'({1'b0, r_r, 1'b0})); mul_b = ca_r; end
      OP_EY: begin mul_a = 35'(signed'({1'b0, r_r})); mul_b = sa_r; end
      OP_XA: begin mul_a = 35'(ex_r); mul_b = cr_r; end
      OP_XB: begin mul_a = 35'(ey_r); mul_b = sr_r; end
      OP_YA: begin mul_a = 35'(ey_r); mul_b = cr_r; end
      default: begin mul_a = 35'(ex_r); mul_b = sr_r; end
    endcase
  end

  assign rnd15 = prod_r + (69'sd1 <<< 14);
  assign sum_x = acc_r - 70'(prod_r);
  assign sum_y = acc_r + 70'(prod_r);
  assign fin_x = finish(sum_x, cx_r);
  assign fin_y = finish(sum_y, cy_r);

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_EX;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) state_r <= ST_ROT;
        end
        ST_ROT: begin
          if (cor_done) state_r <= ST_VSTART;
        end
        ST_VSTART: state_r <= ST_VWAIT;
        ST_VWAIT: begin
          if (cor_done) begin
            op_r <= OP_EX;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_ACC;
        ST_ACC: begin
          if (op_r == OP_YB) state_r <= ST_EMIT;
          else begin
            op_r <= op_r + 3'd1;
            state_r <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (idx_r + 6'd1 == n_r) state_r <= ST_CLOSE;
            else state_r <= ST_VSTART;
            idx_r <= idx_r + 6'd1;
          end
        end
        ST_CLOSE: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (accept) idx_r <= '0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      r_r <= in_radius;
      col_r <= in_color;
      n_r <= n_in;
      step_r <= rep_pkg::StepTab[n_in];
      ang_r <= '0;
    end
    if (state_r == ST_ROT && cor_done) begin
      cr_r <= cor_cos;
      sr_r <= cor_sin;
    end
    if (state_r == ST_VWAIT && cor_done) begin
      ca_r <= cor_cos;
      sa_r <= cor_sin;
    end
    if (state_r == ST_MUL) prod_r <= mul_a * mul_b;
    if (state_r == ST_ACC) begin
      case (op_r)
        OP_EX: ex_r <= rnd15[48:15];
        OP_EY: ey_r <= rnd15[48:15];
        OP_XA: acc_r <= 70'(prod_r);
        OP_XB: vx_r <= fin_x;
        OP_YA: acc_r <= 70'(prod_r);
        default: vy_r <= fin_y;
      endcase
    end
    if (state_r == ST_EMIT && out_free) begin
      out_x_r <= vx_r;
      out_y_r <= vy_r;
      out_col_r <= col_r;
      out_idx_r <= idx_r;
      out_last_r <= 1'b0;
      ang_r <= ang_r + step_r;
      if (idx_r == 6'd0) begin
        fx_r <= vx_r;
        fy_r <= vy_r;
      end
    end
    if (state_r == ST_CLOSE && out_free) begin
      out_x_r <= fx_r;
      out_y_r <= fy_r;
      out_col_r <= col_r;
      out_idx_r <= n_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_vertex_x = out_x_r;
  assign out_vertex_y = out_y_r;
  assign out_vertex_color = out_col_r;
  assign out_vertex_index = out_idx_r;
  assign out_last = out_last_r;

  // The sine and cosine unit only finishes while the sequencer waits on it.
  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == ST_ROT || state_r == ST_VWAIT))
    else $error("CORDIC finished outside a wait state");

  // The closing vertex carries the request's vertex count as its index.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE && out_free) |=> (out_last && out_vertex_index == n_r))
    else $error("closing vertex index mismatch");

  // A vertex is never emitted beyond the request's count.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r < n_r))
    else $error("vertex index beyond count");

  // Accepting a request always starts the rotation angle computation.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ROT))
    else $error("request accepted without starting");

endmodule
